### rtl/sbs_pkg.sv
package sbs_pkg;

    localparam int MAG_W     = 16;
    localparam int BAND_W    = 9;
    localparam int RATE_W    = 9;
    localparam int SCALE_W   = 13;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 16;
    localparam int DIV_STEPS = 4;
    localparam int DIV_STGS  = MAG_W / DIV_STEPS;
    localparam int COEFF_W   = SCALE_W + MAG_W;
    localparam int PROD_SH   = 24;
    localparam int PROD_W    = MAG_W + COEFF_W - PROD_SH;

    localparam logic [RATE_W-1:0] RATE_FULL = RATE_W'(256);

    localparam logic [CFG_AW-1:0] CFG_RATE   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_MAPEN  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_WATCH  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_TLOW   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_THIGH  = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_SCALE  = 3'd5;

    // one item on its way through the divider
    typedef struct packed {
        logic              valid;
        logic [BAND_W-1:0] band;
        logic              mv;
        logic [MAG_W-1:0]  s;
        logic [MAG_W-1:0]  p;
        logic [MAG_W:0]    rem;
        logic [MAG_W-1:0]  q;
    } t_div;

    typedef struct packed {
        logic              valid;
        logic [BAND_W-1:0] band;
        logic [MAG_W-1:0]  s;
        logic [MAG_W-1:0]  p;
        logic [MAG_W-1:0]  lvl;
        logic              mv;
        logic [MAG_W-1:0]  mval;
    } t_res;

    typedef struct packed {
        logic               map_en;
        logic [BAND_W-1:0]  watch;
        logic [RATE_W-1:0]  rate;
        logic [MAG_W-1:0]   tlow;
        logic [MAG_W-1:0]   thigh;
        logic [SCALE_W-1:0] scale;
    } t_cfg;

endpackage

### rtl/sbs_update.sv
module sbs_update
    import sbs_pkg::*;
#(
    parameter int BANDS = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_accept,
    input  logic [BAND_W-1:0] i_band,
    input  logic [MAG_W-1:0]  i_left,
    input  logic [MAG_W-1:0]  i_right,
    input  t_cfg              i_cfg,
    output logic              o_busy,
    output t_div              o_div
);

    localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1;

    logic [MAG_W-1:0] r_smem [BANDS];
    logic [MAG_W-1:0] r_pmem [BANDS];

    logic [AW-1:0]     r_clr;
    logic              r_busy;
    logic              r1_valid, r1_hit, r1_mv;
    logic [BAND_W-1:0] r1_band;
    logic [AW-1:0]     r1_addr;
    logic [MAG_W-1:0]  r1_avg, r1_srd, r1_prd;
    t_div              r2;

    logic [AW+BAND_W-1:0] in_wide;
    logic [AW-1:0]        in_addr;
    logic                 in_hit;
    logic [MAG_W:0]       sum;
    logic                 fwd;
    logic [MAG_W-1:0]     old_s, old_p, new_p, new_s;
    logic [RATE_W-1:0]    rate_c;
    logic [MAG_W+RATE_W-1:0] acc;
    t_div                 n_2;

    assign in_wide = (AW+BAND_W)'(i_band);
    assign in_addr = in_wide[AW-1:0];
    assign in_hit  = in_wide < (AW+BAND_W)'(BANDS);
    assign sum     = {1'b0, i_left} + {1'b0, i_right};

    always_comb begin
        // older item one stage ahead was written to the store too late for this item's read
        fwd    = r2.valid && (r2.band == r1_band) && r1_hit;
        old_s  = fwd ? r2.s : r1_srd;
        old_p  = fwd ? r2.p : r1_prd;
        new_p  = (r1_avg > old_p) ? r1_avg : old_p;
        rate_c = (i_cfg.rate > RATE_FULL) ? RATE_FULL : i_cfg.rate;
        acc    = (MAG_W+RATE_W)'(old_s) * (MAG_W+RATE_W)'(RATE_FULL - rate_c)
               + (MAG_W+RATE_W)'(r1_avg) * (MAG_W+RATE_W)'(rate_c)
               + (MAG_W+RATE_W)'(128);
        new_s  = acc[MAG_W+7:8];
        n_2.valid = r1_valid;
        n_2.band  = r1_band;
        n_2.mv    = r1_mv;
        n_2.s     = r1_hit ? new_s : '0;
        n_2.p     = r1_hit ? new_p : '0;
        n_2.rem   = {1'b0, n_2.s};
        n_2.q     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_clr  <= '0;
        end else if (r_busy) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == AW'(BANDS - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_smem[r_clr] <= '0;
            r_pmem[r_clr] <= '0;
        end else if (i_en && r1_valid && r1_hit) begin
            r_smem[r1_addr] <= new_s;
            r_pmem[r1_addr] <= new_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_srd  <= r_smem[in_addr];
            r1_prd  <= r_pmem[in_addr];
            r1_band <= i_band;
            r1_addr <= in_addr;
            r1_hit  <= in_hit;
            r1_avg  <= sum[MAG_W:1];
            r1_mv   <= in_hit && i_cfg.map_en && (i_band == i_cfg.watch);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2.valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_accept;
            r2.valid <= n_2.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2.band <= n_2.band;
            r2.mv   <= n_2.mv;
            r2.s    <= n_2.s;
            r2.p    <= n_2.p;
            r2.rem  <= n_2.rem;
            r2.q    <= n_2.q;
        end
    end

    assign o_busy = r_busy;
    assign o_div  = r2;

endmodule

### rtl/sbs_div_stage.sv
module sbs_div_stage
    import sbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_div,
    output t_div o_div
);

    t_div r_d, n_d;
    logic [MAG_W:0] rem;
    logic [MAG_W:0] dvs;

    always_comb begin
        n_d = i_div;
        rem = i_div.rem;
        dvs = {1'b0, i_div.p};
        for (int k = 0; k < DIV_STEPS; k++) begin
            rem = {rem[MAG_W-1:0], 1'b0};
            if (rem >= dvs) begin
                rem     = rem - dvs;
                n_d.q   = {n_d.q[MAG_W-2:0], 1'b1};
            end else begin
                n_d.q   = {n_d.q[MAG_W-2:0], 1'b0};
            end
        end
        n_d.rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d.valid <= n_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d.band <= n_d.band;
            r_d.mv   <= n_d.mv;
            r_d.s    <= n_d.s;
            r_d.p    <= n_d.p;
            r_d.rem  <= n_d.rem;
            r_d.q    <= n_d.q;
        end
    end

    assign o_div = r_d;

endmodule

### rtl/sbs_map.sv
module sbs_map
    import sbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_div,
    input  t_cfg i_cfg,
    output t_res o_res
);

    logic               ra_valid, rb_valid;
    logic [BAND_W-1:0]  ra_band, rb_band;
    logic [MAG_W-1:0]   ra_s, ra_p, ra_lvl, rb_s, rb_p, rb_lvl;
    logic               ra_mv, rb_mv;
    logic [COEFF_W-1:0] ra_coeff;
    logic [PROD_W-1:0]  rb_prod;
    t_res               r_res;

    logic [MAG_W-1:0]      lvl, span;
    logic                  inv;
    logic [MAG_W+COEFF_W-1:0] prod;
    logic [PROD_W:0]       v;
    logic [MAG_W-1:0]      mval;

    always_comb begin
        // zero peak gives level zero; smoothed at or above peak saturates
        if (i_div.p == '0)         lvl = '0;
        else if (i_div.s >= i_div.p) lvl = '1;
        else                       lvl = i_div.q;
        inv  = i_cfg.tlow > i_cfg.thigh;
        span = inv ? '0 : i_cfg.thigh - i_cfg.tlow;
        prod = span * ra_coeff;
        v    = (PROD_W+1)'(i_cfg.tlow) + (PROD_W+1)'(rb_prod);
        if (inv)                                  mval = i_cfg.tlow;
        else if (v > (PROD_W+1)'(i_cfg.thigh))    mval = i_cfg.thigh;
        else                                      mval = v[MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_valid    <= 1'b0;
            rb_valid    <= 1'b0;
            r_res.valid <= 1'b0;
        end else if (i_en) begin
            ra_valid    <= i_div.valid;
            rb_valid    <= ra_valid;
            r_res.valid <= rb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            ra_band  <= i_div.band;
            ra_s     <= i_div.s;
            ra_p     <= i_div.p;
            ra_mv    <= i_div.mv;
            ra_lvl   <= lvl;
            ra_coeff <= COEFF_W'(i_cfg.scale) * COEFF_W'(lvl);
            rb_band  <= ra_band;
            rb_s     <= ra_s;
            rb_p     <= ra_p;
            rb_mv    <= ra_mv;
            rb_lvl   <= ra_lvl;
            rb_prod  <= prod[MAG_W+COEFF_W-1:PROD_SH];
            r_res.band <= rb_band;
            r_res.s    <= rb_s;
            r_res.p    <= rb_p;
            r_res.lvl  <= rb_lvl;
            r_res.mv   <= rb_mv;
            r_res.mval <= rb_mv ? mval : '0;
        end
    end

    assign o_res = r_res;

endmodule

### rtl/spectrum_band_smoother_top.sv
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid / tready    tdata: band_index, left_mag, right_mag
// m_axis    out  tvalid / tready    tdata: out_band .. mapped_value; tuser: mapped_valid
// cfg       in   i_cfg_we           i_cfg_addr, i_cfg_data
//
// One item per cycle while m_axis is not stalled and no clear pass runs; from accept
// to result valid an item passes one store read, one update, four divider stages of
// four quotient bits, two multiplier stages and the clamp/output register.
// After reset a clearing pass zeroes both band stores with s_axis_tready low;
// configuration writes are taken throughout.
// A stall on m_axis freezes every stage together, so nothing is lost or repeated.
module spectrum_band_smoother_top
    import sbs_pkg::*;
#(
    parameter int BANDS = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [47:0]       s_axis_tdata,   // band_index[8:0], left_mag[24:9], right_mag[40:25]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [79:0]       m_axis_tdata,   // out_band, smoothed, peak, norm_level, mapped_value
    output logic [0:0]        m_axis_tuser,   // mapped_valid
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic en, busy, accept;
    t_div div_q [DIV_STGS+1];
    t_res res;

    // hold configuration; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate   <= RATE_W'(38);
            r_cfg.map_en <= 1'b0;
            r_cfg.watch  <= '0;
            r_cfg.tlow   <= '0;
            r_cfg.thigh  <= '1;
            r_cfg.scale  <= SCALE_W'(256);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_RATE:  r_cfg.rate   <= i_cfg_data[RATE_W-1:0];
                CFG_MAPEN: r_cfg.map_en <= i_cfg_data[0];
                CFG_WATCH: r_cfg.watch  <= i_cfg_data[BAND_W-1:0];
                CFG_TLOW:  r_cfg.tlow   <= i_cfg_data;
                CFG_THIGH: r_cfg.thigh  <= i_cfg_data;
                CFG_SCALE: r_cfg.scale  <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // advance the whole pipe whenever the output slot is free or being taken
    assign en            = !res.valid || m_axis_tready;
    assign s_axis_tready = en && !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    sbs_update #(.BANDS(BANDS)) u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_accept (accept),
        .i_band   (s_axis_tdata[8:0]),
        .i_left   (s_axis_tdata[24:9]),
        .i_right  (s_axis_tdata[40:25]),
        .i_cfg    (r_cfg),
        .o_busy   (busy),
        .o_div    (div_q[0])
    );

    for (genvar g = 0; g < DIV_STGS; g++) begin : g_div
        sbs_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_div   (div_q[g]),
            .o_div   (div_q[g+1])
        );
    end

    sbs_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_div   (div_q[DIV_STGS]),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    assign m_axis_tvalid = res.valid;
    assign m_axis_tdata  = {7'b0, res.mval, res.lvl, res.p, res.s, res.band};
    assign m_axis_tuser  = res.mv;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !s_axis_tready)
        else $error("item accepted during store clear");
    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[72:57] == 16'd0))
        else $error("mapped value nonzero without mapped_valid");
    a_zero_peak_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[40:25] == 16'd0) |-> (m_axis_tdata[56:41] == 16'd0))
        else $error("nonzero level with zero peak");
`endif

endmodule

### sim/spectrum_band_smoother_top_tb.sv
module spectrum_band_smoother_top_tb;
    import sbs_pkg::*;

    localparam int NBANDS      = 512;
    localparam int LATENCY     = 8;
    localparam int CYCLE_LIMIT = 400000;

    // expected result of one band update
    typedef struct {
        logic [8:0]  band;
        logic [15:0] smoothed;
        logic [15:0] peak;
        logic [15:0] level;
        logic        map_valid;
        logic [15:0] map_value;
    } band_result_t;

    // predicts band updates and checks results against them
    class band_scoreboard;
        logic [15:0]  smooth_mem [NBANDS];
        logic [15:0]  peak_mem [NBANDS];
        logic [8:0]   rate;
        logic         map_en;
        logic [8:0]   watch;
        logic [15:0]  tlow;
        logic [15:0]  thigh;
        logic [12:0]  scale;
        band_result_t pending [$];
        int           errors;

        function void clear();
            foreach (smooth_mem[i]) begin
                smooth_mem[i] = '0;
                peak_mem[i]   = '0;
            end
            rate = 9'd38; map_en = 1'b0; watch = '0;
            tlow = '0; thigh = 16'hFFFF; scale = 13'd256;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_RATE:  rate   = val[8:0];
                CFG_MAPEN: map_en = val[0];
                CFG_WATCH: watch  = val[8:0];
                CFG_TLOW:  tlow   = val;
                CFG_THIGH: thigh  = val;
                CFG_SCALE: scale  = val[12:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic [8:0] band, logic [15:0] lm, logic [15:0] rm);
            band_result_t e;
            logic [16:0]  avg;
            logic [8:0]   r;
            logic [31:0]  s;
            logic [47:0]  q;
            logic [63:0]  v;
            e = '{band, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0};
            if (band < NBANDS) begin
                avg = ({1'b0, lm} + {1'b0, rm}) >> 1;
                e.peak = (avg[15:0] > peak_mem[band]) ? avg[15:0] : peak_mem[band];
                r = (rate > 9'd256) ? 9'd256 : rate;
                s = (32'(smooth_mem[band]) * (32'd256 - 32'(r)) + 32'(avg) * 32'(r)
                     + 32'd128) >> 8;
                e.smoothed = s[15:0];
                smooth_mem[band] = e.smoothed;
                peak_mem[band]   = e.peak;
                if (e.peak != 0) begin
                    q = (48'(e.smoothed) << 16) / 48'(e.peak);
                    e.level = (q > 48'hFFFF) ? 16'hFFFF : q[15:0];
                end
                e.map_valid = map_en && (band == watch);
                if (e.map_valid) begin
                    if (tlow > thigh) begin
                        e.map_value = tlow;
                    end else begin
                        v = 64'(tlow) + ((64'(thigh - tlow) * (64'(scale) * 64'(e.level))) >> 24);
                        e.map_value = (v > 64'(thigh)) ? thigh : v[15:0];
                    end
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [79:0] data, logic mv);
            band_result_t e;
            if (pending.size() == 0) begin
                $error("result with no pending item: data %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[8:0] != e.band) begin
                $error("out_band exp %0d got %0d", e.band, data[8:0]); errors++;
            end
            if (data[24:9] != e.smoothed) begin
                $error("smoothed_mag exp %0d got %0d", e.smoothed, data[24:9]); errors++;
            end
            if (data[40:25] != e.peak) begin
                $error("peak_mag exp %0d got %0d", e.peak, data[40:25]); errors++;
            end
            if (data[56:41] != e.level) begin
                $error("norm_level exp %0d got %0d", e.level, data[56:41]); errors++;
            end
            if (data[72:57] != e.map_value) begin
                $error("mapped_value exp %0d got %0d", e.map_value, data[72:57]); errors++;
            end
            if (mv != e.map_valid) begin
                $error("mapped_valid exp %0d got %0d", e.map_valid, mv); errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [79:0]       m_axis_tdata;
    logic [0:0]        m_axis_tuser;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_data;

    band_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  cycles;

    spectrum_band_smoother_top #(.BANDS(NBANDS)) u_top (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sample results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    // vary receiver backpressure on the falling edge
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // write one register; the block must be idle
    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // present one item and hold it until accepted
    task automatic send_item(logic [8:0] band, logic [15:0] lm, logic [15:0] rm);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, rm, lm, band};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(band, lm, rm);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_mag();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // one sweep of consecutive bands with random content; about one item in ten goes to a random band instead
    task automatic send_sweep(int count);
        logic [8:0] b;
        b = 9'($urandom);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0)
                send_item(9'($urandom), rand_mag(), rand_mag());
            else
                send_item(b, rand_mag(), rand_mag());
            b = b + 9'd1;
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b1;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = '0;
        i_cfg_data     = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero peak, saturated level, band extremes, mapping
        write_reg(CFG_MAPEN, 16'd1);
        write_reg(CFG_WATCH, 16'd0);
        send_item(9'd0, 16'h0000, 16'h0000);
        send_item(9'd0, 16'hFFFF, 16'hFFFF);
        send_item(9'd511, 16'hFFFF, 16'h0000);
        send_item(9'd0, 16'h0000, 16'h0000);
        drain();
        write_reg(CFG_RATE, 16'd256);
        write_reg(CFG_WATCH, 16'd511);
        write_reg(CFG_SCALE, 16'd5120);
        write_reg(CFG_TLOW, 16'd1000);
        write_reg(CFG_THIGH, 16'd60000);
        send_item(9'd511, 16'h1234, 16'h8000);
        send_item(9'd511, 16'h0001, 16'h0000);
        send_item(9'd7, 16'hFFFF, 16'hFFFF);
        drain();
        // rate above a full step, inverted bounds, unknown index, rate zero
        write_reg(CFG_RATE, 16'h01FF);
        write_reg(CFG_TLOW, 16'hFFFF);
        write_reg(CFG_THIGH, 16'd0);
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'h0000);
        send_item(9'd511, 16'h4000, 16'h4000);
        send_item(9'd3, 16'h8000, 16'h7FFF);
        drain();
        write_reg(CFG_RATE, 16'd0);
        write_reg(CFG_TLOW, 16'd0);
        write_reg(CFG_THIGH, 16'hFFFF);
        write_reg(CFG_SCALE, 16'd26);
        send_item(9'd511, 16'hFFFF, 16'hFFFF);
        send_item(9'd3, 16'h0000, 16'h0000);
        drain();

        // random phases: each idling mix with fresh settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            write_reg(CFG_RATE, (ph == 4) ? 16'd1 : 16'($urandom_range(1, 300)));
            write_reg(CFG_MAPEN, 16'($urandom_range(1)) | 16'(ph < 2));
            write_reg(CFG_WATCH, 16'($urandom_range(511)));
            write_reg(CFG_TLOW, (ph == 5) ? 16'd0 : 16'($urandom_range(30000)));
            write_reg(CFG_THIGH, (ph == 6) ? 16'hFFFF : 16'($urandom_range(20000, 65535)));
            write_reg(CFG_SCALE, 16'($urandom_range(26, 5120)));
            // revisit the watched band often so mapping gets exercised
            for (int k = 0; k < 4; k++) begin
                send_sweep(16);
                send_item(sb.watch, rand_mag(), rand_mag());
            end
            // closing stretch; sender idling is switched off only in the phases that idle the sender alone
            send_idle_pct = (ph % 4 == 1) ? 0 : send_idle_pct;
            send_sweep(10);
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### spectrum_band_smoother_top.f
rtl/sbs_pkg.sv
rtl/sbs_update.sv
rtl/sbs_div_stage.sv
rtl/sbs_map.sv
rtl/spectrum_band_smoother_top.sv
sim/spectrum_band_smoother_top_tb.sv
